// ===== rtl/ekdm_pkg.sv =====
// Shared types and constants for the earliest-k dedup merger.
`default_nettype none

package ekdm_pkg;

    // List depth and derived index width
    localparam int SLOTS = 4;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int AGE_W    = 20;
    localparam int MINUTE_W = 27;  // floor((2^32 - 1) / 60) fits in 27 bits

    localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(3600);

    // t / 60 == (t * ceil(2^37 / 60)) >> 37 for every 32-bit t
    localparam logic [TIME_W-1:0] MIN_RECIP = 32'h8888_8889;
    localparam int                MIN_SHIFT = 37;

    // Input item codes
    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_RT     = 2'd1,
        FUNC_HINT   = 2'd2,
        FUNC_FINISH = 2'd3
    } func_t;

    // One list entry, carried cell to cell
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   time_s;
        logic [MINUTE_W-1:0] minute;
        logic                hint;
    } entry_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } cell_ctrl_t;

endpackage : ekdm_pkg

`default_nettype wire

// ===== rtl/ekdm_screen.sv =====
// Candidate qualification, minute computation and hint-usability decision.
`default_nettype none

module ekdm_screen
    import ekdm_pkg::*;
(
    input  wire logic [1:0]          func,
    input  wire logic [TIME_W-1:0]   now_time,
    input  wire logic [TIME_W-1:0]   fetched_time,
    input  wire logic [TIME_W-1:0]   cand_time,
    input  wire logic                cand_valid,
    input  wire logic [TIME_W-1:0]   current_time,
    input  wire logic                hints_usable,
    input  wire logic [AGE_W-1:0]    max_hint_age,
    output logic                     cand_ok,
    output logic                     cand_hint,
    output logic [MINUTE_W-1:0]      cand_minute,
    output logic                     hints_next
);

    logic [2*TIME_W-1:0] prod;
    logic [TIME_W-1:0]   age_diff;
    logic                not_past;

    // Minute index by reciprocal multiply
    assign prod        = {{TIME_W{1'b0}}, cand_time} * {{TIME_W{1'b0}}, MIN_RECIP};
    assign cand_minute = prod[MIN_SHIFT +: MINUTE_W];

    // Hints usable: fetched, and either in the future or young enough
    assign age_diff   = now_time - fetched_time;
    assign hints_next = (fetched_time != '0) &&
                        ((fetched_time > now_time) ||
                         (age_diff < {{(TIME_W-AGE_W){1'b0}}, max_hint_age}));

    assign not_past = (cand_time >= current_time);

    // Acceptance by item kind
    always_comb begin
        cand_ok   = 1'b0;
        cand_hint = 1'b0;
        unique case (func_t'(func))
            FUNC_RT: begin
                cand_ok = cand_valid && not_past;
            end
            FUNC_HINT: begin
                cand_ok   = hints_usable && (cand_time != '0) && not_past;
                cand_hint = 1'b1;
            end
            FUNC_START, FUNC_FINISH: begin
                cand_ok = 1'b0;
            end
            default: begin
                cand_ok = 1'b0;
            end
        endcase
    end

endmodule : ekdm_screen

`default_nettype wire

// ===== rtl/ekdm_cell.sv =====
// One slot of the sorted list: compare, insert-shift and rotate.
`default_nettype none

module ekdm_cell
    import ekdm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     cand,
    input  wire entry_t     left_entry,
    input  wire logic       left_take,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            take,
    output logic            dup
);

    entry_t entry_reg;
    entry_t entry_next;

    // Slot yields to the candidate when empty or later than it
    assign take  = !entry_reg.valid || (cand.time_s < entry_reg.time_s);
    assign dup   = entry_reg.valid && (entry_reg.minute == cand.minute);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (ctrl.clear) begin
            entry_next.valid = 1'b0;
        end else if (ctrl.insert) begin
            if (take) begin
                entry_next = left_take ? left_entry : cand;
            end
        end else if (ctrl.rotate) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid  <= 1'b0;
            entry_reg.time_s <= '0;
            entry_reg.minute <= '0;
            entry_reg.hint   <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule : ekdm_cell

`default_nettype wire

// ===== rtl/earliest_k_dedup_merger_core.sv =====
// Top level of the earliest-k dedup merger: control, registers and cell chain.
`default_nettype none

// Keeps the SLOTS earliest departure times in ascending order in a chain of
// cells; times in one whole minute count once. A start item clears the list
// and latches the time and hint decision. A candidate is qualified and gets
// its minute index from a reciprocal multiply when it is accepted; in the
// insert state it is compared against every cell and the sorted insert is
// done in one shift of the chain. A finish item rotates the chain once per
// result, stalling while m_ready holds off a result; the list is intact
// after the last result. The next item is taken as soon as the last result
// sits in the output register.
module earliest_k_dedup_merger_core
    import ekdm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [AGE_W-1:0]   cfg_wdata,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [TIME_W-1:0]  s_now_time,
    input  wire logic [TIME_W-1:0]  s_fetched_time,
    input  wire logic [TIME_W-1:0]  s_cand_time,
    input  wire logic               s_cand_valid,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_slot_valid,
    output logic [TIME_W-1:0]       m_slot_time,
    output logic                    m_slot_is_hint,
    output logic                    m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [AGE_W-1:0]    age_reg;
    logic [TIME_W-1:0]   cur_time_reg;
    logic                hints_reg;
    entry_t              pend_reg;
    logic                pend_ok_reg;
    logic                m_valid_reg;
    logic                m_slot_valid_reg;
    logic [TIME_W-1:0]   m_slot_time_reg;
    logic                m_slot_is_hint_reg;
    logic                m_last_reg;

    logic                accept;
    logic                cand_ok;
    logic                cand_hint;
    logic [MINUTE_W-1:0] cand_minute;
    logic                hints_next;
    logic                emit_load;
    logic                dup_any;
    cell_ctrl_t          ctrl;

    entry_t              cell_entry [SLOTS];
    entry_t              left_entry [SLOTS];
    entry_t              right_entry [SLOTS];
    logic [SLOTS-1:0]    cell_take;
    logic [SLOTS-1:0]    cell_dup;
    logic [SLOTS-1:0]    left_take;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    ekdm_screen u_screen (
        .func         (s_func),
        .now_time     (s_now_time),
        .fetched_time (s_fetched_time),
        .cand_time    (s_cand_time),
        .cand_valid   (s_cand_valid),
        .current_time (cur_time_reg),
        .hints_usable (hints_reg),
        .max_hint_age (age_reg),
        .cand_ok      (cand_ok),
        .cand_hint    (cand_hint),
        .cand_minute  (cand_minute),
        .hints_next   (hints_next)
    );

    // Chain commands
    assign dup_any   = |cell_dup;
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.clear  = accept && (func_t'(s_func) == FUNC_START);
        ctrl.insert = (state_reg == ST_INSERT) && pend_ok_reg && !dup_any;
        ctrl.rotate = emit_load;
    end

    // Neighbor wiring: shift right on insert, rotate left on emit
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0) begin
                left_entry[i] = '0;
                left_take[i]  = 1'b0;
            end else begin
                left_entry[i] = cell_entry[i-1];
                left_take[i]  = cell_take[i-1];
            end
            right_entry[i] = (i == SLOTS-1) ? cell_entry[0] : cell_entry[(i+1) % SLOTS];
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ekdm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .cand        (pend_reg),
            .left_entry  (left_entry[g]),
            .left_take   (left_take[g]),
            .right_entry (right_entry[g]),
            .entry       (cell_entry[g]),
            .take        (cell_take[g]),
            .dup         (cell_dup[g])
        );
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg <= AGE_RESET;
        end else if (cfg_we) begin
            age_reg <= cfg_wdata;
        end
    end

    // Pending candidate, filled at acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg.valid  <= 1'b1;
            pend_reg.time_s <= s_cand_time;
            pend_reg.minute <= cand_minute;
            pend_reg.hint   <= cand_hint;
        end
    end

    // Control FSM and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cur_time_reg <= '0;
            hints_reg    <= 1'b0;
            pend_ok_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            // drop the held result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && !emit_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        pend_ok_reg <= cand_ok;
                        unique case (func_t'(s_func))
                            FUNC_START: begin
                                cur_time_reg <= s_now_time;
                                hints_reg    <= hints_next;
                            end
                            FUNC_RT, FUNC_HINT: begin
                                state_reg <= ST_INSERT;
                            end
                            FUNC_FINISH: begin
                                cnt_reg   <= '0;
                                state_reg <= ST_EMIT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INSERT: begin
                    state_reg <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_valid_reg        <= 1'b1;
                        m_slot_valid_reg   <= cell_entry[0].valid;
                        m_slot_time_reg    <= cell_entry[0].valid ? cell_entry[0].time_s : '0;
                        m_slot_is_hint_reg <= cell_entry[0].valid && cell_entry[0].hint;
                        m_last_reg         <= (cnt_reg == IDX_W'(SLOTS-1));
                        cnt_reg            <= cnt_reg + 1'b1;
                        if (cnt_reg == IDX_W'(SLOTS-1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot_valid   = m_slot_valid_reg;
    assign m_slot_time    = m_slot_time_reg;
    assign m_slot_is_hint = m_slot_is_hint_reg;
    assign m_last         = m_last_reg;

endmodule : earliest_k_dedup_merger_core

`default_nettype wire

// ===== verif/tb_earliest_k_dedup_merger_core.sv =====
// Self-checking testbench for the earliest-k dedup merger core.
`timescale 1ns / 100ps

module tb_earliest_k_dedup_merger_core;
    import ekdm_pkg::*;

    // One input transaction as offered on the s_ channel
    typedef struct {
        func_t             func;
        logic [TIME_W-1:0] now_t;
        logic [TIME_W-1:0] fetch_t;
        logic [TIME_W-1:0] cand_t;
        logic              cand_v;
    } feed_item_t;

    // One emitted slot as seen on the m_ channel
    typedef struct {
        logic              sv;
        logic [TIME_W-1:0] st;
        logic              sh;
        logic              lst;
    } slot_rec_t;

    localparam int IDLE_PCT   = 11;
    localparam int HOLD_LEN   = 150;
    localparam int STALL_LIM  = 4000;
    localparam int SETTLE_CYC = 10;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_we         = 1'b0;
    logic [AGE_W-1:0]  cfg_wdata      = AGE_RESET;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [1:0]        s_func         = FUNC_START;
    logic [TIME_W-1:0] s_now_time     = '0;
    logic [TIME_W-1:0] s_fetched_time = '0;
    logic [TIME_W-1:0] s_cand_time    = '0;
    logic              s_cand_valid   = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_slot_valid;
    logic [TIME_W-1:0] m_slot_time;
    logic              m_slot_is_hint;
    logic              m_last;

    earliest_k_dedup_merger_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_now_time     (s_now_time),
        .s_fetched_time (s_fetched_time),
        .s_cand_time    (s_cand_time),
        .s_cand_valid   (s_cand_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_valid   (m_slot_valid),
        .m_slot_time    (m_slot_time),
        .m_slot_is_hint (m_slot_is_hint),
        .m_last         (m_last)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    feed_item_t pending_q[$];
    slot_rec_t  slots_due_q[$];
    feed_item_t offered;
    int         errors     = 0;
    bit         no_idle    = 1'b0;
    bit         hold_armed = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left  = 0;
    int         quiet_cyc  = 0;

    // Model of the sorted list, session time, hint decision and age register
    logic              lm_valid[SLOTS] = '{default: 1'b0};
    logic [TIME_W-1:0] lm_time[SLOTS]  = '{default: '0};
    logic              lm_hint[SLOTS]  = '{default: 1'b0};
    logic [TIME_W-1:0] lm_now          = '0;
    logic              lm_hints_ok     = 1'b0;
    logic [AGE_W-1:0]  lm_age          = AGE_RESET;

    // Dedup by minute, then fill a free slot or displace the latest entry
    task automatic insert_departure(logic [TIME_W-1:0] t, logic hint);
        int                pos;
        int                j;
        logic              v;
        logic [TIME_W-1:0] tt;
        logic              h;
        pos = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (lm_valid[i] && (lm_time[i] / 60 == t / 60)) return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!lm_valid[i]) begin
                pos = i;
                break;
            end
        end
        if (pos < 0) begin
            if (t < lm_time[SLOTS-1]) pos = SLOTS - 1;
            else return;
        end
        lm_valid[pos] = 1'b1;
        lm_time[pos]  = t;
        lm_hint[pos]  = hint;
        // equal times keep arrival order, hence strict compare
        for (j = pos; j > 0 && lm_time[j] < lm_time[j-1]; j--) begin
            v  = lm_valid[j]; tt = lm_time[j]; h = lm_hint[j];
            lm_valid[j] = lm_valid[j-1]; lm_time[j] = lm_time[j-1];
            lm_hint[j]  = lm_hint[j-1];
            lm_valid[j-1] = v; lm_time[j-1] = tt; lm_hint[j-1] = h;
        end
    endtask

    // Advance the model by one accepted transaction, queue the slots it emits
    task automatic predict_slots(feed_item_t it);
        slot_rec_t r;
        case (it.func)
            FUNC_START: begin
                for (int i = 0; i < SLOTS; i++) begin
                    lm_valid[i] = 1'b0; lm_time[i] = '0; lm_hint[i] = 1'b0;
                end
                lm_now = it.now_t;
                if (it.fetch_t == 0)             lm_hints_ok = 1'b0;
                else if (it.fetch_t > it.now_t)  lm_hints_ok = 1'b1;
                else lm_hints_ok = ((it.now_t - it.fetch_t) < {12'd0, lm_age});
            end
            FUNC_RT: begin
                if (it.cand_v && it.cand_t >= lm_now) insert_departure(it.cand_t, 1'b0);
            end
            FUNC_HINT: begin
                if (lm_hints_ok && it.cand_t != 0 && it.cand_t >= lm_now)
                    insert_departure(it.cand_t, 1'b1);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    r.sv  = lm_valid[i];
                    r.st  = lm_valid[i] ? lm_time[i] : '0;
                    r.sh  = lm_valid[i] & lm_hint[i];
                    r.lst = (i == SLOTS - 1);
                    slots_due_q.push_back(r);
                end
            end
        endcase
    endtask

    // Driver: predicts each accepted transaction, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (cfg_we) lm_age = cfg_wdata;
            if (s_valid && s_ready) predict_slots(offered);
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    offered         = pending_q.pop_front();
                    s_valid        <= 1'b1;
                    s_func         <= offered.func;
                    s_now_time     <= offered.now_t;
                    s_fetched_time <= offered.fetch_t;
                    s_cand_time    <= offered.cand_t;
                    s_cand_valid   <= offered.cand_v;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Monitor: compares each result transaction, drives m_ready
    always @(posedge aclk) begin
        slot_rec_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (slots_due_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual time %0d",
                             $time, m_slot_time);
                    errors++;
                end else begin
                    e = slots_due_q.pop_front();
                    check_field("slot_valid", e.sv, m_slot_valid);
                    check_field("slot_time", e.st, m_slot_time);
                    check_field("slot_is_hint", e.sh, m_slot_is_hint);
                    check_field("last", e.lst, m_last);
                end
            end
            // long hold-off to back the block up into its input
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready  <= 1'b0;
            end else if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_LEN;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cyc <= 0;
            else quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= STALL_LIM) begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cyc);
                $display("[earliest_k_dedup_merger_core] ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(func_t f, logic [TIME_W-1:0] n, logic [TIME_W-1:0] fe,
                             logic [TIME_W-1:0] c, logic v);
        feed_item_t it;
        it.func = f; it.now_t = n; it.fetch_t = fe; it.cand_t = c; it.cand_v = v;
        pending_q.push_back(it);
    endtask

    // Wait until everything sent has been answered, then let the core settle
    task automatic drain(int extra);
        while (pending_q.size() > 0 || s_valid || slots_due_q.size() > 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_age(logic [AGE_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // One session: start, a burst of candidates near the session time, finish
    task automatic add_session(int n_cand, logic [AGE_W-1:0] age, ref int count);
        logic [TIME_W-1:0] nw;
        logic [TIME_W-1:0] fe;
        logic [TIME_W-1:0] c;
        func_t             f;
        nw = $urandom;
        case ($urandom_range(0, 5))
            0: fe = '0;
            1: fe = nw - $urandom_range(0, age - 1);
            2: fe = nw - age - $urandom_range(0, 1000);
            3: fe = nw + $urandom_range(1, 100);
            4: fe = $urandom;
            default: fe = nw - (age - $urandom_range(0, 1));
        endcase
        push_item(FUNC_START, nw, fe, $urandom, 1'($urandom_range(0, 1)));
        count++;
        for (int k = 0; k < n_cand; k++) begin
            case ($urandom_range(0, 9))
                7: c = nw - $urandom_range(1, 120);
                8: c = $urandom;
                9: c = nw;
                default: c = nw + $urandom_range(0, 900);
            endcase
            f = $urandom_range(0, 1) ? FUNC_HINT : FUNC_RT;
            push_item(f, $urandom, $urandom, c, $urandom_range(0, 9) != 0);
            count++;
            // occasional noise transaction of any kind
            if ($urandom_range(0, 9) == 0) begin
                push_item(func_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
                count++;
            end
        end
        push_item(FUNC_FINISH, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        count++;
    endtask

    task automatic random_phase(logic [AGE_W-1:0] age, int target);
        int count;
        count = 0;
        write_age(age);
        while (count < target) add_session($urandom_range(1, 9), age, count);
        drain(SETTLE_CYC);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: default age, written explicitly
        write_age(AGE_RESET);
        // candidates before any start use the reset session state
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd100, 1'b1);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd200, 1'b1);
        push_item(FUNC_FINISH, 32'd0, 32'd0, 32'd0,   1'b0);
        // fetch later than now counts as usable; zero hint time is refused
        push_item(FUNC_START,  32'd0, 32'd5, 32'd0, 1'b0);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd0, 1'b1);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'hFFFF_FFC0, 1'b1);
        push_item(FUNC_FINISH, 32'd0, 32'd0, 32'd0, 1'b0);
        // never fetched; past, invalid, dedup, fill, displace, drop when full
        push_item(FUNC_START,  32'd1000, 32'd0, 32'd0, 1'b0);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd2000, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd999,  1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd1000, 1'b0);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd1000, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd1059, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd1019, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd5000, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd3000, 1'b1);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd4000, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd4000, 1'b1);
        push_item(FUNC_RT,     32'd0, 32'd0, 32'd9000, 1'b1);
        push_item(FUNC_FINISH, 32'd0, 32'd0, 32'd0, 1'b0);
        // hint age boundary: one second inside, then exactly at the limit
        push_item(FUNC_START,  32'd100000, 32'd96401, 32'd0, 1'b0);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd100500, 1'b0);
        push_item(FUNC_FINISH, 32'd0, 32'd0, 32'd0, 1'b0);
        push_item(FUNC_START,  32'd100000, 32'd96400, 32'd0, 1'b0);
        push_item(FUNC_HINT,   32'd0, 32'd0, 32'd100500, 1'b1);
        push_item(FUNC_FINISH, 32'd0, 32'd0, 32'd0, 1'b0);
        drain(SETTLE_CYC);

        // smallest age, both sides without idling
        no_idle = 1'b1;
        random_phase(20'd1, 15);
        no_idle = 1'b0;

        // largest age; receiver holds off while finishes pile up
        write_age(20'd604800);
        hold_armed = 1'b1;
        begin
            int count;
            count = 0;
            while (count < 15) add_session($urandom_range(2, 8), 20'd604800, count);
        end
        repeat (3) push_item(FUNC_FINISH, $urandom, $urandom, $urandom, 1'b1);
        drain(SETTLE_CYC);

        random_phase(20'($urandom_range(1, 604800)), 20);
        random_phase(20'($urandom_range(1, 7200)), 20);
        random_phase(20'($urandom_range(1, 604800)), 15);

        drain(20);
        if (errors == 0) begin
            $display("[earliest_k_dedup_merger_core] OK");
        end else begin
            $display("[earliest_k_dedup_merger_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== earliest_k_dedup_merger_core.f =====
rtl/ekdm_pkg.sv
rtl/ekdm_screen.sv
rtl/ekdm_cell.sv
rtl/earliest_k_dedup_merger_core.sv
verif/tb_earliest_k_dedup_merger_core.sv
